// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the strip binarizer RTL.
// Needs nothing else; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Consequence that must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequence that must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/sab_pkg.sv =====
// Shared constants, codes and types of the strip adaptive binarizer.
// Used by every module of the block; depends on nothing.
package sab_pkg;

   // Strip store geometry.
   localparam int MAX_STRIP_PIXELS = 4096;
   localparam int STRIP_ADDR_W     = $clog2(MAX_STRIP_PIXELS);
   localparam int STORE_ADDR_W     = STRIP_ADDR_W + 1;
   localparam int STORE_DEPTH      = 2 * MAX_STRIP_PIXELS;
   localparam int COUNT_W          = $clog2(MAX_STRIP_PIXELS + 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_STRIP_PIXELS);

   // Pixel fields.
   localparam int PIX_W      = 8;
   localparam int WORD_W     = 3 * PIX_W;
   localparam logic [PIX_W-1:0] PIX_MIN = '0;
   localparam logic [PIX_W-1:0] PIX_MAX = '1;
   localparam logic [PIX_W-1:0] BIN_ON  = '1;
   localparam logic [PIX_W-1:0] BIN_OFF = '0;

   // Configuration registers.
   localparam int STRIP_PIXELS_W = 13;
   localparam int TOLERANCE_W    = 8;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_PIXELS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE    = 1'b1;
   localparam logic [STRIP_PIXELS_W-1:0] STRIP_PIXELS_RESET = 13'd768;
   localparam logic [TOLERANCE_W-1:0]    TOLERANCE_RESET    = 8'd3;

   // Ceiling division of the range: dividend is range plus divisor minus one.
   localparam int DIVIDEND_W = PIX_W + 1;
   localparam int DIV_STEP_W = $clog2(DIVIDEND_W + 1);

   // Item queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Item kinds as sorted by the front.
   localparam logic [1:0] KIND_DRAIN       = 2'd0;
   localparam logic [1:0] KIND_CLOSE       = 2'd1;
   localparam logic [1:0] KIND_PIXEL       = 2'd2;
   localparam logic [1:0] KIND_PIXEL_CLOSE = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [PIX_W-1:0] c2;
      logic [PIX_W-1:0] c1;
      logic [PIX_W-1:0] c0;
   } item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/core/sab_front.sv =====
// Front of the strip binarizer: accepts request transfers, sorts each item
// by kind and queues it for the back. Depends on sab_pkg.
`include "assert_macros.svh"

module sab_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [sab_pkg::PIX_W-1:0] req_pixel_c0,
   input  logic [sab_pkg::PIX_W-1:0] req_pixel_c1,
   input  logic [sab_pkg::PIX_W-1:0] req_pixel_c2,
   input  logic                      req_has_pixel,
   input  logic                      req_close_strip,
   output logic                      q_valid,
   output sab_pkg::item_type         q_item,
   input  logic                      q_pop
);

   sab_pkg::item_type                queue_mem [sab_pkg::QUEUE_DEPTH];
   logic [sab_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [sab_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [sab_pkg::QUEUE_PTR_W:0]    count_ff, count_in;
   logic [1:0]                       kind;
   logic                             push;

   // Sort the incoming item by whether it stores a pixel and closes a strip.
   always_comb begin
      unique case ({req_has_pixel, req_close_strip})
         2'b00: kind = sab_pkg::KIND_DRAIN;
         2'b01: kind = sab_pkg::KIND_CLOSE;
         2'b10: kind = sab_pkg::KIND_PIXEL;
         2'b11: kind = sab_pkg::KIND_PIXEL_CLOSE;
         default: kind = sab_pkg::KIND_DRAIN;
      endcase
   end

   // Queue handshake: stall only when every slot is taken.
   assign req_stall = (count_ff == (sab_pkg::QUEUE_PTR_W + 1)'(sab_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_mem[rd_ptr_ff];

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= '{kind: kind, c2: req_pixel_c2, c1: req_pixel_c1,
                                   c0: req_pixel_c0};
      end
   end

   `ASSERT_SAME(a_pop_nonempty, clock, reset, q_pop, count_ff != '0, "pop from empty queue")
   `ASSERT_NEXT(a_count_grows, clock, reset, push && !q_pop, count_ff == $past(count_ff) + 1'b1, "queue level lost a transfer")

endmodule

// ===== rtl/core/sab_divider.sv =====
// Restoring divider of the strip binarizer, one quotient bit per cycle.
// Produces the ceiling offset of the upper threshold. Depends on sab_pkg.
`include "assert_macros.svh"

module sab_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [sab_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [sab_pkg::TOLERANCE_W-1:0]     divisor,
   output sab_pkg::div_status_type             status,
   output logic [sab_pkg::DIVIDEND_W-1:0]      quotient
);

   logic [sab_pkg::DIVIDEND_W-1:0]  rem_ff, rem_in;
   logic [sab_pkg::DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [sab_pkg::TOLERANCE_W-1:0] dsr_ff, dsr_in;
   logic [sab_pkg::DIV_STEP_W-1:0]  step_ff, step_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [sab_pkg::DIVIDEND_W:0]    trial;
   logic                            fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff, quo_ff[sab_pkg::DIVIDEND_W-1]};
   assign fits  = (trial >= {2'b00, dsr_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         step_in = sab_pkg::DIV_STEP_W'(sab_pkg::DIVIDEND_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? sab_pkg::DIVIDEND_W'(trial - {2'b00, dsr_ff})
                        : trial[sab_pkg::DIVIDEND_W-1:0];
         quo_in  = {quo_ff[sab_pkg::DIVIDEND_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == sab_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign status   = '{busy: busy_ff, done: done_ff};
   assign quotient = quo_ff;

   `ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && !done_ff, "divider did not start")
   `ASSERT_SAME(a_quot_fits, clock, reset, done_ff, !quo_ff[sab_pkg::DIVIDEND_W-1], "offset exceeds pixel range")

endmodule

// ===== rtl/core/sab_back.sv =====
// Back of the strip binarizer: configuration registers, ping-pong strip
// store, min/max tracking, threshold update and the drain output stage.
// Depends on sab_pkg; the division is done by sab_divider outside.
`include "assert_macros.svh"

module sab_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [sab_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sab_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                  q_valid,
   input  sab_pkg::item_type                     q_item,
   output logic                                  q_pop,
   output logic                                  div_start,
   output logic [sab_pkg::DIVIDEND_W-1:0]        div_dividend,
   output logic [sab_pkg::TOLERANCE_W-1:0]       div_divisor,
   input  sab_pkg::div_status_type               div_status,
   input  logic [sab_pkg::DIVIDEND_W-1:0]        div_quotient,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sab_pkg::PIX_W-1:0]             rsp_bin_c0,
   output logic [sab_pkg::PIX_W-1:0]             rsp_bin_c1,
   output logic [sab_pkg::PIX_W-1:0]             rsp_bin_c2,
   output logic                                  rsp_strip_last
);

   localparam logic S_RUN = 1'b0;
   localparam logic S_DIV = 1'b1;

   localparam int PW = sab_pkg::PIX_W;
   localparam int CW = sab_pkg::COUNT_W;

   function automatic logic [PW-1:0] min_of(input logic [PW-1:0] a, input logic [PW-1:0] b);
      return (b < a) ? b : a;
   endfunction

   function automatic logic [PW-1:0] max_of(input logic [PW-1:0] a, input logic [PW-1:0] b);
      return (b > a) ? b : a;
   endfunction

   function automatic logic [PW-1:0] binarize(input logic [PW-1:0] v,
                                              input logic [PW-1:0] low,
                                              input logic [PW-1:0] high);
      return (v < low || v > high) ? sab_pkg::BIN_ON : sab_pkg::BIN_OFF;
   endfunction

   // Configuration registers.
   logic [sab_pkg::STRIP_PIXELS_W-1:0] strip_pixels_ff, strip_pixels_in;
   logic [sab_pkg::TOLERANCE_W-1:0]    tolerance_ff, tolerance_in;

   // Strip state.
   logic                state_ff, state_in;
   logic                fill_bank_ff, fill_bank_in;
   logic [CW-1:0]       fill_count_ff, fill_count_in;
   logic [PW-1:0]       run_min_ff, run_min_in;
   logic [PW-1:0]       run_max_ff, run_max_in;
   logic [PW-1:0]       drain_low_ff, drain_low_in;
   logic [PW-1:0]       drain_high_ff, drain_high_in;
   logic [CW-1:0]       drain_count_ff, drain_count_in;
   logic [CW-1:0]       drain_total_ff, drain_total_in;
   logic [PW-1:0]       pend_low_ff, pend_low_in;
   logic [PW-1:0]       close_max_ff, close_max_in;

   // Read and output stages.
   logic                rd_valid_ff, rd_valid_in;
   logic                rd_last_ff, rd_last_in;
   logic [sab_pkg::WORD_W-1:0] mem_rd_ff;
   logic                out_valid_ff, out_valid_in;
   logic [PW-1:0]       out_c0_ff, out_c1_ff, out_c2_ff;
   logic                out_last_ff;

   logic [sab_pkg::WORD_W-1:0] store_mem [sab_pkg::STORE_DEPTH];

   logic                          rd_moves, rd_free, drain_pending, item_go;
   logic                          store_req, close_req, do_store, do_read, do_close, load_go;
   logic [CW-1:0]                 limit, new_count;
   logic [PW-1:0]                 new_min, new_max, diff;
   logic [sab_pkg::TOLERANCE_W-1:0] tol_eff;
   logic [sab_pkg::STORE_ADDR_W-1:0] wr_addr, rd_addr;

   // Effective strip length and divisor after clamping.
   always_comb begin
      if (strip_pixels_ff == '0) begin
         limit = CW'(1);
      end else if (strip_pixels_ff > sab_pkg::MAX_COUNT) begin
         limit = sab_pkg::MAX_COUNT;
      end else begin
         limit = CW'(strip_pixels_ff);
      end
      tol_eff = (tolerance_ff == '0) ? sab_pkg::TOLERANCE_W'(1) : tolerance_ff;
   end

   // Item issue: a drain step needs the read stage free in the next cycle.
   assign rd_moves      = !out_valid_ff || !rsp_stall;
   assign rd_free       = !rd_valid_ff || rd_moves;
   assign drain_pending = (drain_count_ff < drain_total_ff);
   assign item_go       = (state_ff == S_RUN) && q_valid && (!drain_pending || rd_free);
   assign q_pop         = item_go;

   assign store_req = (q_item.kind == sab_pkg::KIND_PIXEL) ||
                      (q_item.kind == sab_pkg::KIND_PIXEL_CLOSE);
   assign close_req = (q_item.kind == sab_pkg::KIND_CLOSE) ||
                      (q_item.kind == sab_pkg::KIND_PIXEL_CLOSE);

   assign do_read   = item_go && drain_pending;
   assign do_store  = item_go && store_req && (fill_count_ff < sab_pkg::MAX_COUNT);
   assign new_count = fill_count_ff + CW'(do_store);
   assign do_close  = item_go && (new_count != '0) &&
                      (close_req || new_count >= limit);

   assign wr_addr = {fill_bank_ff, fill_count_ff[sab_pkg::STRIP_ADDR_W-1:0]};
   assign rd_addr = {~fill_bank_ff, drain_count_ff[sab_pkg::STRIP_ADDR_W-1:0]};

   // Running extremes including the pixel stored by this item.
   always_comb begin
      new_min = run_min_ff;
      new_max = run_max_ff;
      if (do_store) begin
         new_min = min_of(min_of(min_of(run_min_ff, q_item.c0), q_item.c1), q_item.c2);
         new_max = max_of(max_of(max_of(run_max_ff, q_item.c0), q_item.c1), q_item.c2);
      end
   end

   // Closing a strip starts the ceiling division of its range.
   assign diff         = new_max - new_min;
   assign div_start    = do_close;
   assign div_divisor  = tol_eff;
   assign div_dividend = {1'b0, diff} + {1'b0, tol_eff} - 1'b1;
   assign pend_low_in  = do_close ? new_min + (diff >> 3) : pend_low_ff;
   assign close_max_in = do_close ? new_max : close_max_ff;

   // New thresholds take effect once the last pixel of the old strip is binarized.
   assign load_go = (state_ff == S_DIV) && div_status.done && !rd_valid_ff;

   always_comb begin
      strip_pixels_in = strip_pixels_ff;
      tolerance_in    = tolerance_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            sab_pkg::CSR_STRIP_PIXELS:
               strip_pixels_in = csr_write_data[sab_pkg::STRIP_PIXELS_W-1:0];
            sab_pkg::CSR_TOLERANCE:
               tolerance_in = csr_write_data[sab_pkg::TOLERANCE_W-1:0];
            default: ;
         endcase
      end
   end

   // Strip bookkeeping and sequencing.
   always_comb begin
      state_in       = state_ff;
      fill_bank_in   = fill_bank_ff;
      fill_count_in  = fill_count_ff;
      run_min_in     = run_min_ff;
      run_max_in     = run_max_ff;
      drain_low_in   = drain_low_ff;
      drain_high_in  = drain_high_ff;
      drain_count_in = drain_count_ff;
      drain_total_in = drain_total_ff;
      if (do_read) begin
         drain_count_in = drain_count_ff + 1'b1;
      end
      if (item_go) begin
         fill_count_in = new_count;
         run_min_in    = new_min;
         run_max_in    = new_max;
      end
      if (do_close) begin
         drain_total_in = new_count;
         drain_count_in = '0;
         fill_bank_in   = ~fill_bank_ff;
         fill_count_in  = '0;
         run_min_in     = sab_pkg::PIX_MAX;
         run_max_in     = sab_pkg::PIX_MIN;
         state_in       = S_DIV;
      end
      if (load_go) begin
         drain_low_in  = pend_low_ff;
         drain_high_in = close_max_ff - div_quotient[PW-1:0];
         state_in      = S_RUN;
      end
   end

   // Read stage and output register.
   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (do_read) begin
         rd_valid_in = 1'b1;
      end else if (rd_moves) begin
         rd_valid_in = 1'b0;
      end
      rd_last_in = do_read ? (CW'(drain_count_ff + 1'b1) == drain_total_ff) : rd_last_ff;
      out_valid_in = out_valid_ff;
      if (rd_valid_ff && rd_moves) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_pixels_ff <= sab_pkg::STRIP_PIXELS_RESET;
         tolerance_ff    <= sab_pkg::TOLERANCE_RESET;
         state_ff        <= S_RUN;
         fill_bank_ff    <= 1'b0;
         fill_count_ff   <= '0;
         run_min_ff      <= sab_pkg::PIX_MAX;
         run_max_ff      <= sab_pkg::PIX_MIN;
         drain_low_ff    <= '0;
         drain_high_ff   <= '0;
         drain_count_ff  <= '0;
         drain_total_ff  <= '0;
         rd_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         strip_pixels_ff <= strip_pixels_in;
         tolerance_ff    <= tolerance_in;
         state_ff        <= state_in;
         fill_bank_ff    <= fill_bank_in;
         fill_count_ff   <= fill_count_in;
         run_min_ff      <= run_min_in;
         run_max_ff      <= run_max_in;
         drain_low_ff    <= drain_low_in;
         drain_high_ff   <= drain_high_in;
         drain_count_ff  <= drain_count_in;
         drain_total_ff  <= drain_total_in;
         rd_valid_ff     <= rd_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_low_ff  <= pend_low_in;
      close_max_ff <= close_max_in;
      rd_last_ff   <= rd_last_in;
      if (rd_valid_ff && rd_moves) begin
         out_c0_ff   <= binarize(mem_rd_ff[PW-1:0], drain_low_ff, drain_high_ff);
         out_c1_ff   <= binarize(mem_rd_ff[2*PW-1:PW], drain_low_ff, drain_high_ff);
         out_c2_ff   <= binarize(mem_rd_ff[3*PW-1:2*PW], drain_low_ff, drain_high_ff);
         out_last_ff <= rd_last_ff;
      end
   end

   // Ping-pong strip store: fill bank written, drain bank read.
   always_ff @(posedge clock) begin
      if (do_store) begin
         store_mem[wr_addr] <= {q_item.c2, q_item.c1, q_item.c0};
      end
      if (do_read) begin
         mem_rd_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_bin_c0     = out_c0_ff;
   assign rsp_bin_c1     = out_c1_ff;
   assign rsp_bin_c2     = out_c2_ff;
   assign rsp_strip_last = out_last_ff;

   `ASSERT_SAME(a_bank_split, clock, reset, do_read && do_store, rd_addr[sab_pkg::STORE_ADDR_W-1] != wr_addr[sab_pkg::STORE_ADDR_W-1], "fill and drain hit the same bank")
   `ASSERT_NEXT(a_read_held, clock, reset, rd_valid_ff && !rd_moves, $stable(mem_rd_ff), "stalled read data was overwritten")
   `ASSERT_SAME(a_drain_bound, clock, reset, 1'b1, drain_count_ff <= drain_total_ff, "drain ran past strip end")

endmodule

// ===== rtl/core/strip_adaptive_binarizer_top.sv =====
// Top level of the strip adaptive binarizer.
// Connects sab_front, sab_back and sab_divider; depends on sab_pkg.

// Pixels are taken in strips of strip_pixels (clamped to 1..4096) and each
// strip is emitted binarized one strip later, one result per request transfer
// while an older strip is still draining; drain-only requests flush the last
// strip and close_strip ends a short strip. The front takes one request
// transfer per cycle into a four-entry queue while a slot is free, and the
// back executes one queued item per cycle. Closing a strip holds the back
// while the bit-serial ceiling divider sets the upper threshold and then
// until the new thresholds are loaded. The back also waits whenever the
// response side stalls with a drain result pending. Store contents are not
// cleared at reset; only written pixels are ever read back.
module strip_adaptive_binarizer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [sab_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sab_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sab_pkg::PIX_W-1:0]         req_pixel_c0,
   input  logic [sab_pkg::PIX_W-1:0]         req_pixel_c1,
   input  logic [sab_pkg::PIX_W-1:0]         req_pixel_c2,
   input  logic                              req_has_pixel,
   input  logic                              req_close_strip,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sab_pkg::PIX_W-1:0]         rsp_bin_c0,
   output logic [sab_pkg::PIX_W-1:0]         rsp_bin_c1,
   output logic [sab_pkg::PIX_W-1:0]         rsp_bin_c2,
   output logic                              rsp_strip_last
);

   logic                                 q_valid;
   logic                                 q_pop;
   sab_pkg::item_type                    q_item;
   logic                                 div_start;
   logic [sab_pkg::DIVIDEND_W-1:0]       div_dividend;
   logic [sab_pkg::TOLERANCE_W-1:0]      div_divisor;
   sab_pkg::div_status_type              div_status;
   logic [sab_pkg::DIVIDEND_W-1:0]       div_quotient;

   // Request side: accept and queue items.
   sab_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_c0    (req_pixel_c0),
      .req_pixel_c1    (req_pixel_c1),
      .req_pixel_c2    (req_pixel_c2),
      .req_has_pixel   (req_has_pixel),
      .req_close_strip (req_close_strip),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   // Threshold offset divider.
   sab_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Strip store, thresholds and response side.
   sab_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .div_start      (div_start),
      .div_dividend   (div_dividend),
      .div_divisor    (div_divisor),
      .div_status     (div_status),
      .div_quotient   (div_quotient),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bin_c0     (rsp_bin_c0),
      .rsp_bin_c1     (rsp_bin_c1),
      .rsp_bin_c2     (rsp_bin_c2),
      .rsp_strip_last (rsp_strip_last)
   );

endmodule
